// ===== rtl/core/cylinder_point_sampler_macros.svh =====
// Assertion macros shared by the checker of the cylinder point sampler
`ifndef CYLINDER_POINT_SAMPLER_MACROS_SVH
`define CYLINDER_POINT_SAMPLER_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset
`define CPS_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off during reset
`define CPS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/cps_pkg.sv =====
// Types, codes and constants of the cylinder point sampler
package cps_pkg;

    localparam int CORDIC_STEPS = 24;
    localparam int ROOT_STEPS   = 32;

    localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;

    localparam logic [2:0] SEL_BULK  = 3'd0;
    localparam logic [2:0] SEL_WALL  = 3'd1;
    localparam logic [2:0] SEL_LOWER = 3'd2;
    localparam logic [2:0] SEL_UPPER = 3'd3;
    localparam logic [2:0] SEL_VOID  = 3'd4;

    localparam logic [2:0] REG_MODE     = 3'd0;
    localparam logic [2:0] REG_RADIUS   = 3'd1;
    localparam logic [2:0] REG_LENGTH   = 3'd2;
    localparam logic [2:0] REG_SKIP     = 3'd3;
    localparam logic [2:0] REG_THICK    = 3'd4;
    localparam logic [2:0] REG_W_SIDE   = 3'd5;
    localparam logic [2:0] REG_W_BOTTOM = 3'd6;
    localparam logic [2:0] REG_W_TOP    = 3'd7;

    typedef struct packed {
        logic [31:0] u_angle;
        logic [31:0] u_face;
        logic [31:0] u_thick;
        logic [31:0] u_radial;
        logic [31:0] u_axial;
    } draw_t;

    typedef struct packed {
        logic signed [31:0] point_x;
        logic signed [31:0] point_y;
        logic signed [31:0] point_z;
        logic [2:0]         face_taken;
    } point_t;

    // Sideband that rides along the root and rotation stages
    typedef struct packed {
        logic [2:0]         face;
        logic               lsign;
        logic [30:0]        lmag;
        logic signed [31:0] z;
        logic               flip;
    } sb_t;

    // Arctangent of 2^-i in turns over 2^32
    function automatic logic signed [33:0] turn_atan(input int i);
        logic signed [33:0] t;
        case (i)
            0:  t = 34'sd536870912;
            1:  t = 34'sd316933406;
            2:  t = 34'sd167458907;
            3:  t = 34'sd85004756;
            4:  t = 34'sd42667331;
            5:  t = 34'sd21354465;
            6:  t = 34'sd10679838;
            7:  t = 34'sd5340245;
            8:  t = 34'sd2670163;
            9:  t = 34'sd1335087;
            10: t = 34'sd667544;
            11: t = 34'sd333772;
            12: t = 34'sd166886;
            13: t = 34'sd83443;
            14: t = 34'sd41722;
            15: t = 34'sd20861;
            16: t = 34'sd10430;
            17: t = 34'sd5215;
            18: t = 34'sd2608;
            19: t = 34'sd1304;
            20: t = 34'sd652;
            21: t = 34'sd326;
            22: t = 34'sd163;
            23: t = 34'sd81;
            default: t = 34'sd0;
        endcase
        return t;
    endfunction

endpackage

// ===== rtl/core/cylinder_point_sampler.sv =====
// Cylinder point sampler: five uniform draws in, one Q16.16 point out per beat
//
// The block turns one draw beat (five 32-bit uniform fractions) into one point beat
// (x, y, z in Q16.16, saturated, plus the face code) and keeps no state between beats.
// It is a 40-stage pipeline followed by an output register and a one-entry skid
// buffer: a new draw beat is taken every cycle while the skid buffer is empty, that
// is while the output side keeps up. The pipeline depth is set by the 32-stage
// square-root pipeline (one result bit per stage), in whose first 24 stages the
// 24-step sine/cosine rotation runs side by side; five stages ahead of it form the
// shell radius squared and the z coordinate, three stages after it scale the radius
// and rotate it onto x and y. draw_ready drops only while the skid buffer holds a
// point, that is while the output is stalled; then the whole pipeline holds.
// Registers sit on an APB port at byte address 4*i (mode, radius, length, skip,
// thickness, side, bottom and top weights); pready is always high, reads return
// the register. Write them only while no beat is in flight.
module cylinder_point_sampler
    import cps_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        draw_valid,
    output logic        draw_ready,
    input  draw_t       draw,
    output logic        point_valid,
    input  logic        point_ready,
    output point_t      point
);

    localparam int NSTAGE = 40;

    // ---------------- configuration registers ----------------
    logic               mode_reg;
    logic [30:0]        radius_reg;
    logic [30:0]        length_reg;
    logic signed [31:0] skip_reg;
    logic [30:0]        thick_reg;
    logic [31:0]        w_side_reg;
    logic [31:0]        w_bottom_reg;
    logic [31:0]        w_top_reg;

    logic cfg_wr;
    assign cfg_wr = psel & penable & pwrite;
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= 1'b0;
            radius_reg   <= '0;
            length_reg   <= '0;
            skip_reg     <= '0;
            thick_reg    <= '0;
            w_side_reg   <= '0;
            w_bottom_reg <= '0;
            w_top_reg    <= '0;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[4:2])
                REG_MODE:     mode_reg     <= pwdata[0];
                REG_RADIUS:   radius_reg   <= pwdata[30:0];
                REG_LENGTH:   length_reg   <= pwdata[30:0];
                REG_SKIP:     skip_reg     <= $signed(pwdata);
                REG_THICK:    thick_reg    <= pwdata[30:0];
                REG_W_SIDE:   w_side_reg   <= pwdata;
                REG_W_BOTTOM: w_bottom_reg <= pwdata;
                REG_W_TOP:    w_top_reg    <= pwdata;
                default:      ;
            endcase
        end
    end

    always_comb
    begin
        unique case (paddr[4:2])
            REG_MODE:     prdata = {31'b0, mode_reg};
            REG_RADIUS:   prdata = {1'b0, radius_reg};
            REG_LENGTH:   prdata = {1'b0, length_reg};
            REG_SKIP:     prdata = skip_reg;
            REG_THICK:    prdata = {1'b0, thick_reg};
            REG_W_SIDE:   prdata = w_side_reg;
            REG_W_BOTTOM: prdata = w_bottom_reg;
            REG_W_TOP:    prdata = w_top_reg;
            default:      prdata = '0;
        endcase
    end

    // ---------------- pipeline control ----------------
    // One shared enable: every stage advances unless the skid buffer is full.
    logic               en;
    logic               skid_v_reg;
    logic [1:NSTAGE]    vld_reg;
    point_t             res_c;

    assign en         = ~skid_v_reg;
    assign draw_ready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {draw_valid, vld_reg[1:NSTAGE-1]};
        end
    end

    // ---------------- stage 1: face choice, radii, z operands, angle fold ----------------
    logic [29:0]        half_thick_c;
    logic signed [33:0] rmin_c;
    logic signed [33:0] rmax_c;
    logic [33:0]        amag_c;
    logic [33:0]        bmag_c;
    logic signed [31:0] lbulk_c;
    logic [2:0]         face_c;
    logic               flip_c;

    logic [2:0]         s1_face_reg;
    logic [31:0]        s1_a_reg;
    logic [31:0]        s1_b_reg;
    logic               s1_lsign_reg;
    logic [30:0]        s1_lmag_reg;
    logic signed [31:0] s1_zc_reg;
    logic signed [31:0] s1_zlen_reg;
    logic signed [32:0] s1_capbase_reg;
    logic [31:0]        s1_urad_reg;
    logic signed [31:0] s1_ang_reg;
    logic               s1_flip_reg;

    always_comb
    begin
        half_thick_c = thick_reg[30:1];
        rmin_c = $signed({3'b0, radius_reg}) + $signed({{2{skip_reg[31]}}, skip_reg})
               - $signed({4'b0, half_thick_c});
        rmax_c = rmin_c + $signed({3'b0, thick_reg});
        amag_c = rmin_c[33] ? 34'(-rmin_c) : 34'(rmin_c);
        bmag_c = rmax_c[33] ? 34'(-rmax_c) : 34'(rmax_c);
        lbulk_c = $signed({1'b0, radius_reg}) - $signed({2'b0, half_thick_c});

        if (!mode_reg)
            face_c = SEL_BULK;
        else if (draw.u_face < w_side_reg)
            face_c = SEL_WALL;
        else if (draw.u_face < w_bottom_reg)
            face_c = SEL_LOWER;
        else if (draw.u_face < w_top_reg)
            face_c = SEL_UPPER;
        else
            face_c = SEL_VOID;

        // fold the second and third quarter turn onto the first and fourth
        flip_c = draw.u_angle[31] ^ draw.u_angle[30];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_face_reg <= face_c;
            // saturate shell radii before squaring
            s1_a_reg <= (|amag_c[33:32]) ? 32'hFFFF_FFFF : amag_c[31:0];
            s1_b_reg <= (|bmag_c[33:32]) ? 32'hFFFF_FFFF : bmag_c[31:0];
            if (face_c == SEL_BULK)
            begin
                s1_lsign_reg <= lbulk_c[31];
                s1_lmag_reg  <= lbulk_c[31] ? 31'(-lbulk_c) : lbulk_c[30:0];
            end
            else
            begin
                s1_lsign_reg <= 1'b0;
                s1_lmag_reg  <= radius_reg;
            end
            case (face_c)
                SEL_BULK:
                begin
                    s1_zc_reg   <= $signed({~draw.u_axial[31], draw.u_axial[30:0]});
                    s1_zlen_reg <= $signed({1'b0, length_reg}) - $signed({1'b0, thick_reg});
                end
                SEL_WALL:
                begin
                    s1_zc_reg   <= $signed({~draw.u_axial[31], draw.u_axial[30:0]});
                    s1_zlen_reg <= $signed({1'b0, length_reg});
                end
                default:
                begin
                    s1_zc_reg   <= $signed({~draw.u_thick[31], draw.u_thick[30:0]});
                    s1_zlen_reg <= $signed({1'b0, thick_reg});
                end
            endcase
            s1_capbase_reg <= $signed({3'b0, length_reg[30:1]})
                            + $signed({skip_reg[31], skip_reg});
            s1_urad_reg <= draw.u_radial;
            s1_ang_reg  <= $signed({draw.u_angle[31] ^ flip_c, draw.u_angle[30:0]});
            s1_flip_reg <= flip_c;
        end
    end

    // ---------------- stage 2: squares of the shell radii, z product ----------------
    logic [2:0]         s2_face_reg;
    logic [63:0]        s2_a2_reg;
    logic [63:0]        s2_b2_reg;
    logic signed [63:0] s2_zp_reg;
    logic               s2_lsign_reg;
    logic [30:0]        s2_lmag_reg;
    logic signed [32:0] s2_capbase_reg;
    logic [31:0]        s2_urad_reg;
    logic signed [31:0] s2_ang_reg;
    logic               s2_flip_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s2_face_reg    <= s1_face_reg;
            s2_a2_reg      <= 64'(s1_a_reg) * 64'(s1_a_reg);
            s2_b2_reg      <= 64'(s1_b_reg) * 64'(s1_b_reg);
            s2_zp_reg      <= 64'(s1_zc_reg) * 64'(s1_zlen_reg);
            s2_lsign_reg   <= s1_lsign_reg;
            s2_lmag_reg    <= s1_lmag_reg;
            s2_capbase_reg <= s1_capbase_reg;
            s2_urad_reg    <= s1_urad_reg;
            s2_ang_reg     <= s1_ang_reg;
            s2_flip_reg    <= s1_flip_reg;
        end
    end

    // ---------------- stage 3: square difference, final z ----------------
    logic signed [31:0] zcent_c;
    logic signed [33:0] cap_c;
    logic signed [33:0] zfull_c;

    logic [2:0]         s3_face_reg;
    logic               s3_ge_reg;
    logic [63:0]        s3_d_reg;
    logic [63:0]        s3_a2_reg;
    logic signed [31:0] s3_z_reg;
    logic               s3_lsign_reg;
    logic [30:0]        s3_lmag_reg;
    logic [31:0]        s3_urad_reg;
    logic signed [31:0] s3_ang_reg;
    logic               s3_flip_reg;

    always_comb
    begin
        // floor of the product over 2^32 is its upper half
        zcent_c = s2_zp_reg[63:32];
        cap_c   = $signed({s2_capbase_reg[32], s2_capbase_reg})
                + $signed({{2{zcent_c[31]}}, zcent_c});
        case (s2_face_reg) inside
            SEL_BULK, SEL_WALL: zfull_c = $signed({{2{zcent_c[31]}}, zcent_c});
            SEL_LOWER:          zfull_c = -cap_c;
            SEL_UPPER:          zfull_c = cap_c;
            default:            zfull_c = '0;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s3_face_reg <= s2_face_reg;
            s3_ge_reg   <= s2_b2_reg >= s2_a2_reg;
            s3_d_reg    <= (s2_b2_reg >= s2_a2_reg) ? s2_b2_reg - s2_a2_reg
                                                    : s2_a2_reg - s2_b2_reg;
            s3_a2_reg   <= s2_a2_reg;
            if (zfull_c > 34'sd2147483647)
                s3_z_reg <= 32'sh7FFF_FFFF;
            else if (zfull_c < -34'sd2147483648)
                s3_z_reg <= 32'sh8000_0000;
            else
                s3_z_reg <= zfull_c[31:0];
            s3_lsign_reg <= s2_lsign_reg;
            s3_lmag_reg  <= s2_lmag_reg;
            s3_urad_reg  <= s2_urad_reg;
            s3_ang_reg   <= s2_ang_reg;
            s3_flip_reg  <= s2_flip_reg;
        end
    end

    // ---------------- stage 4: difference times radial fraction, in two halves ----------------
    logic [2:0]         s4_face_reg;
    logic               s4_ge_reg;
    logic [63:0]        s4_ph_reg;
    logic [63:0]        s4_pl_reg;
    logic [63:0]        s4_a2_reg;
    logic signed [31:0] s4_z_reg;
    logic               s4_lsign_reg;
    logic [30:0]        s4_lmag_reg;
    logic [31:0]        s4_urad_reg;
    logic signed [31:0] s4_ang_reg;
    logic               s4_flip_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s4_face_reg  <= s3_face_reg;
            s4_ge_reg    <= s3_ge_reg;
            s4_ph_reg    <= 64'(s3_d_reg[63:32]) * 64'(s3_urad_reg);
            s4_pl_reg    <= 64'(s3_d_reg[31:0]) * 64'(s3_urad_reg);
            s4_a2_reg    <= s3_a2_reg;
            s4_z_reg     <= s3_z_reg;
            s4_lsign_reg <= s3_lsign_reg;
            s4_lmag_reg  <= s3_lmag_reg;
            s4_urad_reg  <= s3_urad_reg;
            s4_ang_reg   <= s3_ang_reg;
            s4_flip_reg  <= s3_flip_reg;
        end
    end

    // ---------------- stage 5 and root stages: square root with rotation alongside ----------------
    // Entry 0 is the root operand; entry j+1 holds the state after root step j.
    logic [63:0]        rt_v_reg   [0:ROOT_STEPS];
    logic [63:0]        rt_res_reg [0:ROOT_STEPS];
    logic signed [33:0] cx_reg     [0:ROOT_STEPS];
    logic signed [33:0] cy_reg     [0:ROOT_STEPS];
    logic signed [33:0] cz_reg     [0:ROOT_STEPS];
    sb_t                sb_reg     [0:ROOT_STEPS];

    logic [63:0] frac_c;
    logic [63:0] r2_c;

    always_comb
    begin
        frac_c = s4_ph_reg + {32'b0, s4_pl_reg[63:32]};
        r2_c   = s4_ge_reg ? s4_a2_reg + frac_c : s4_a2_reg - frac_c;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rt_v_reg[0]   <= (s4_face_reg == SEL_WALL) ? r2_c : {s4_urad_reg, 32'b0};
            rt_res_reg[0] <= '0;
            cx_reg[0]     <= CORDIC_GAIN;
            cy_reg[0]     <= '0;
            cz_reg[0]     <= $signed({{2{s4_ang_reg[31]}}, s4_ang_reg});
            sb_reg[0]     <= '{face: s4_face_reg, lsign: s4_lsign_reg, lmag: s4_lmag_reg,
                               z: s4_z_reg, flip: s4_flip_reg};
        end
    end

    for (genvar j = 0; j < ROOT_STEPS; j++)
    begin : g_step
        localparam logic [63:0] BIT = 64'd1 << (62 - 2 * j);

        logic [64:0] trial_c;
        logic        take_c;

        assign trial_c = {1'b0, rt_res_reg[j]} + {1'b0, BIT};
        assign take_c  = {1'b0, rt_v_reg[j]} >= trial_c;

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (take_c)
                begin
                    rt_v_reg[j+1]   <= rt_v_reg[j] - trial_c[63:0];
                    rt_res_reg[j+1] <= (rt_res_reg[j] >> 1) + BIT;
                end
                else
                begin
                    rt_v_reg[j+1]   <= rt_v_reg[j];
                    rt_res_reg[j+1] <= rt_res_reg[j] >> 1;
                end
                sb_reg[j+1] <= sb_reg[j];
            end
        end

        if (j < CORDIC_STEPS)
        begin : g_rot
            localparam logic signed [33:0] ATAN = turn_atan(j);

            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    // rotate toward zero residual angle
                    if (!cz_reg[j][33])
                    begin
                        cx_reg[j+1] <= cx_reg[j] - (cy_reg[j] >>> j);
                        cy_reg[j+1] <= cy_reg[j] + (cx_reg[j] >>> j);
                        cz_reg[j+1] <= cz_reg[j] - ATAN;
                    end
                    else
                    begin
                        cx_reg[j+1] <= cx_reg[j] + (cy_reg[j] >>> j);
                        cy_reg[j+1] <= cy_reg[j] - (cx_reg[j] >>> j);
                        cz_reg[j+1] <= cz_reg[j] + ATAN;
                    end
                end
            end
        end
        else
        begin : g_hold
            always_ff @(posedge clk)
            begin
                if (en)
                begin
                    cx_reg[j+1] <= cx_reg[j];
                    cy_reg[j+1] <= cy_reg[j];
                    cz_reg[j+1] <= cz_reg[j];
                end
            end
        end
    end

    // ---------------- stage 38: scale product, unfold cos and sin ----------------
    sb_t                sb_end;
    logic [31:0]        root_end;

    logic [2:0]         p1_face_reg;
    logic               p1_lsign_reg;
    logic [62:0]        p1_prod_reg;
    logic [31:0]        p1_root_reg;
    logic signed [33:0] p1_c_reg;
    logic signed [33:0] p1_s_reg;
    logic signed [31:0] p1_z_reg;

    assign sb_end   = sb_reg[ROOT_STEPS];
    assign root_end = rt_res_reg[ROOT_STEPS][31:0];

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p1_face_reg  <= sb_end.face;
            p1_lsign_reg <= sb_end.lsign;
            p1_prod_reg  <= 63'(sb_end.lmag) * 63'(root_end);
            p1_root_reg  <= root_end;
            p1_c_reg     <= sb_end.flip ? -cx_reg[ROOT_STEPS] : cx_reg[ROOT_STEPS];
            p1_s_reg     <= sb_end.flip ? -cy_reg[ROOT_STEPS] : cy_reg[ROOT_STEPS];
            p1_z_reg     <= sb_end.z;
        end
    end

    // ---------------- stage 39: signed radius ----------------
    logic [2:0]         p2_face_reg;
    logic signed [32:0] p2_r_reg;
    logic signed [33:0] p2_c_reg;
    logic signed [33:0] p2_s_reg;
    logic signed [31:0] p2_z_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p2_face_reg <= p1_face_reg;
            case (p1_face_reg)
                SEL_WALL: p2_r_reg <= $signed({1'b0, p1_root_reg});
                SEL_VOID: p2_r_reg <= '0;
                default:
                begin
                    if (p1_lsign_reg)
                        p2_r_reg <= -$signed({2'b0, p1_prod_reg[62:32]});
                    else
                        p2_r_reg <= $signed({2'b0, p1_prod_reg[62:32]});
                end
            endcase
            p2_c_reg <= p1_c_reg;
            p2_s_reg <= p1_s_reg;
            p2_z_reg <= p1_z_reg;
        end
    end

    // ---------------- stage 40: project radius onto x and y ----------------
    logic [2:0]         p3_face_reg;
    logic signed [66:0] p3_rc_reg;
    logic signed [66:0] p3_rs_reg;
    logic signed [31:0] p3_z_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p3_face_reg <= p2_face_reg;
            p3_rc_reg   <= 67'(p2_r_reg) * 67'(p2_c_reg);
            p3_rs_reg   <= 67'(p2_r_reg) * 67'(p2_s_reg);
            p3_z_reg    <= p2_z_reg;
        end
    end

    // ---------------- output register and skid buffer ----------------
    function automatic logic signed [31:0] sat32(input logic signed [36:0] v);
        logic signed [31:0] r;
        if (v > 37'sd2147483647)
            r = 32'sh7FFF_FFFF;
        else if (v < -37'sd2147483648)
            r = 32'sh8000_0000;
        else
            r = v[31:0];
        return r;
    endfunction

    always_comb
    begin
        // drop the Q2.30 scale of cos and sin with a floor shift
        res_c.point_x    = sat32(p3_rc_reg[66:30]);
        res_c.point_y    = sat32(p3_rs_reg[66:30]);
        res_c.point_z    = p3_z_reg;
        res_c.face_taken = p3_face_reg;
    end

    logic   up_fire;
    logic   out_v_reg;
    point_t out_reg;
    point_t skid_reg;

    assign up_fire     = vld_reg[NSTAGE] & ~skid_v_reg;
    assign point_valid = out_v_reg;
    assign point       = out_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_v_reg  <= 1'b0;
            skid_v_reg <= 1'b0;
        end
        else if (~out_v_reg | point_ready)
        begin
            // output free: drain the skid first, else take the new beat
            if (skid_v_reg)
            begin
                out_v_reg  <= 1'b1;
                skid_v_reg <= 1'b0;
            end
            else
            begin
                out_v_reg <= up_fire;
            end
        end
        else if (up_fire)
        begin
            skid_v_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (~out_v_reg | point_ready)
        begin
            out_reg <= skid_v_reg ? skid_reg : res_c;
        end
        else if (up_fire)
        begin
            skid_reg <= res_c;
        end
    end

endmodule

// ===== rtl/core/cps_checker.sv =====
// Port-level checker of the cylinder point sampler and its bind
`include "cylinder_point_sampler_macros.svh"

module cps_checker
    import cps_pkg::*;
(
    input logic   clk,
    input logic   rst_n,
    input logic   draw_ready,
    input logic   point_valid,
    input logic   point_ready,
    input point_t point
);

    logic stalled;
    logic no_face;
    logic at_origin;

    assign stalled   = point_valid && !point_ready;
    assign no_face   = point_valid && point.face_taken == SEL_VOID;
    assign at_origin = point.point_x == 32'sd0 && point.point_y == 32'sd0
                    && point.point_z == 32'sd0;

    `CPS_ASSERT_NEXT(a_point_hold, stalled, point_valid, "point beat dropped while stalled")
    `CPS_ASSERT_NEXT(a_point_stable, stalled, $stable(point), "point beat changed while stalled")
    `CPS_ASSERT_NOW(a_none_origin, no_face, at_origin, "no-face point off origin")
    `CPS_ASSERT_NOW(a_stall_needs_output, !draw_ready, point_valid, "input held, no point")

endmodule

bind cylinder_point_sampler cps_checker u_cps_checker (.*);
